>>> hw/rtl/v3n_pkg.sv
// ----------------------------------------------------------------------------
// v3n_pkg
// Shared widths and defaults for the 3D vector normalisation unit.
// ----------------------------------------------------------------------------
package v3n_pkg;

    localparam int IN_W          = 32;
    localparam int SQ_W          = 64;
    localparam int MAG_W         = 32;
    localparam int SQRT_STEPS    = 32;
    localparam int FRAC_BITS_DEF = 16;

endpackage

>>> hw/rtl/vector3_normalize_unit.sv
// ----------------------------------------------------------------------------
// vector3_normalize_unit
// Euclidean length and unit vector of one signed fixed-point 3D vector.
// Pipeline: absolute values, squares and their sum, one radix-2 step of the
// square root per stage, then one radix-2 step of the three dividers per stage.
// Throughput: one vector per cycle; a stall on the result side holds every stage.
// Reset: synchronous, active low, clears the stage valid bits only.
// ----------------------------------------------------------------------------
module vector3_normalize_unit
    import v3n_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [IN_W-1:0]   i_vec_x,
    input  logic signed [IN_W-1:0]   i_vec_y,
    input  logic signed [IN_W-1:0]   i_vec_z,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [FRAC_BITS+1:0] o_unit_x,
    output logic signed [FRAC_BITS+1:0] o_unit_y,
    output logic signed [FRAC_BITS+1:0] o_unit_z,
    output logic        [MAG_W-1:0]  o_magnitude,
    output logic                     o_zero_vector
);

    localparam int NW = IN_W + FRAC_BITS;
    localparam int QW = FRAC_BITS + 1;
    localparam int UW = FRAC_BITS + 2;

    logic en;

    logic                r_v1;
    logic [IN_W-1:0]     r_abs1 [3];
    logic [2:0]          r_neg1;

    logic                r_v2;
    logic [SQ_W-1:0]     r_sq2  [3];
    logic [IN_W-1:0]     r_abs2 [3];
    logic [2:0]          r_neg2;

    logic                r_sv   [SQRT_STEPS+1];
    logic [SQ_W-1:0]     r_srem [SQRT_STEPS+1];
    logic [SQ_W-1:0]     r_sroot[SQRT_STEPS+1];
    logic [IN_W-1:0]     r_sabs [SQRT_STEPS+1][3];
    logic [2:0]          r_sneg [SQRT_STEPS+1];
    logic [SQ_W-1:0]     n_srem [SQRT_STEPS+1];
    logic [SQ_W-1:0]     n_sroot[SQRT_STEPS+1];

    logic                r_dv   [QW+1];
    logic [NW-1:0]       r_drem [QW+1][3];
    logic [QW-1:0]       r_dq   [QW+1][3];
    logic [MAG_W-1:0]    r_dden [QW+1];
    logic [2:0]          r_dneg [QW+1];
    logic                r_dzero[QW+1];
    logic [NW-1:0]       n_drem [QW+1][3];
    logic [QW-1:0]       n_dq   [QW+1][3];

    logic                r_ov;
    logic [UW-1:0]       r_unit [3];
    logic [MAG_W-1:0]    r_mag;
    logic                r_zero;

    logic [IN_W-1:0]     n_abs  [3];
    logic [2:0]          n_neg;
    logic [UW-1:0]       n_unit [3];

    assign en      = !r_ov || i_ready;
    assign o_ready = en;

    always_comb begin
        logic [SQ_W-1:0] trial;
        logic [NW-1:0]   sden;
        n_neg = {i_vec_z[IN_W-1], i_vec_y[IN_W-1], i_vec_x[IN_W-1]};
        n_abs[0] = i_vec_x[IN_W-1] ? (~i_vec_x + 1'b1) : i_vec_x;
        n_abs[1] = i_vec_y[IN_W-1] ? (~i_vec_y + 1'b1) : i_vec_y;
        n_abs[2] = i_vec_z[IN_W-1] ? (~i_vec_z + 1'b1) : i_vec_z;

        n_srem[0]  = '0;
        n_sroot[0] = '0;
        for (int k = 0; k < SQRT_STEPS; k++) begin
            trial = r_sroot[k] + (SQ_W'(1) << (SQ_W - 2 - 2 * k));
            if (r_srem[k] >= trial) begin
                n_srem[k+1]  = r_srem[k] - trial;
                n_sroot[k+1] = (r_sroot[k] >> 1) + (SQ_W'(1) << (SQ_W - 2 - 2 * k));
            end else begin
                n_srem[k+1]  = r_srem[k];
                n_sroot[k+1] = r_sroot[k] >> 1;
            end
        end

        for (int c = 0; c < 3; c++) begin
            n_drem[0][c] = '0;
            n_dq[0][c]   = '0;
        end
        for (int m = 0; m < QW; m++) begin
            sden = NW'(r_dden[m]) << (FRAC_BITS - m);
            for (int c = 0; c < 3; c++) begin
                if (r_drem[m][c] >= sden) begin
                    n_drem[m+1][c] = r_drem[m][c] - sden;
                    n_dq[m+1][c]   = {r_dq[m][c][QW-2:0], 1'b1};
                end else begin
                    n_drem[m+1][c] = r_drem[m][c];
                    n_dq[m+1][c]   = {r_dq[m][c][QW-2:0], 1'b0};
                end
            end
        end

        for (int c = 0; c < 3; c++) begin
            if (r_dzero[QW]) begin
                n_unit[c] = '0;
            end else if (r_dneg[QW][c]) begin
                n_unit[c] = ~{1'b0, r_dq[QW][c]} + 1'b1;
            end else begin
                n_unit[c] = {1'b0, r_dq[QW][c]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            for (int k = 0; k <= SQRT_STEPS; k++) r_sv[k] <= 1'b0;
            for (int m = 0; m <= QW; m++) r_dv[m] <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1  <= i_valid;
            r_v2  <= r_v1;
            r_sv[0] <= r_v2;
            for (int k = 0; k < SQRT_STEPS; k++) r_sv[k+1] <= r_sv[k];
            r_dv[0] <= r_sv[SQRT_STEPS];
            for (int m = 0; m < QW; m++) r_dv[m+1] <= r_dv[m];
            r_ov <= r_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_abs1 <= n_abs;
            r_neg1 <= n_neg;

            for (int c = 0; c < 3; c++) begin
                r_sq2[c] <= r_abs1[c] * r_abs1[c];
            end
            r_abs2 <= r_abs1;
            r_neg2 <= r_neg1;

            r_srem[0]  <= r_sq2[0] + r_sq2[1] + r_sq2[2];
            r_sroot[0] <= '0;
            r_sabs[0]  <= r_abs2;
            r_sneg[0]  <= r_neg2;
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_srem[k+1]  <= n_srem[k+1];
                r_sroot[k+1] <= n_sroot[k+1];
                r_sabs[k+1]  <= r_sabs[k];
                r_sneg[k+1]  <= r_sneg[k];
            end

            for (int c = 0; c < 3; c++) begin
                r_drem[0][c] <= NW'(r_sabs[SQRT_STEPS][c]) << FRAC_BITS;
                r_dq[0][c]   <= '0;
            end
            r_dden[0]  <= r_sroot[SQRT_STEPS][MAG_W-1:0];
            r_dneg[0]  <= r_sneg[SQRT_STEPS];
            r_dzero[0] <= (r_sroot[SQRT_STEPS] == '0);
            for (int m = 0; m < QW; m++) begin
                r_drem[m+1]  <= n_drem[m+1];
                r_dq[m+1]    <= n_dq[m+1];
                r_dden[m+1]  <= r_dden[m];
                r_dneg[m+1]  <= r_dneg[m];
                r_dzero[m+1] <= r_dzero[m];
            end

            r_unit <= n_unit;
            r_mag  <= r_dden[QW];
            r_zero <= r_dzero[QW];
        end
    end

    assign o_valid       = r_ov;
    assign o_unit_x      = r_unit[0];
    assign o_unit_y      = r_unit[1];
    assign o_unit_z      = r_unit[2];
    assign o_magnitude   = r_mag;
    assign o_zero_vector = r_zero;

endmodule

>>> bench/vector3_normalize_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalize_unit_test
// Streams signed Q16.16 vectors through the normalisation unit under random
// sender gaps and receiver stalls, and checks length, unit vector and the
// zero-length flag of every result against a table or a behavioural predictor.
// ----------------------------------------------------------------------------
module vector3_normalize_unit_test
    import v3n_pkg::*;
();

    localparam int FB      = FRAC_BITS_DEF;
    localparam int UW      = FB + 2;
    localparam int LAT     = FB + 38;
    localparam int N_RAND  = 400;
    localparam int LIMIT   = 200000;

    typedef struct packed {
        logic signed [UW-1:0] ux;
        logic signed [UW-1:0] uy;
        logic signed [UW-1:0] uz;
        logic [MAG_W-1:0]     mag;
        logic                 zero;
    } unit_vec_t;

    typedef struct {
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic signed [IN_W-1:0] z;
        bit                     known;
        unit_vec_t              res;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic signed [IN_W-1:0] i_vec_x = '0;
    logic signed [IN_W-1:0] i_vec_y = '0;
    logic signed [IN_W-1:0] i_vec_z = '0;
    logic o_ready, o_valid, o_zero_vector;
    logic signed [UW-1:0] o_unit_x, o_unit_y, o_unit_z;
    logic [MAG_W-1:0] o_magnitude;

    unit_vec_t expected_q[$];
    int errors = 0;
    int n_sent = 0;
    int n_got = 0;
    int n_zero = 0;
    int cycles = 0;

    always #5 i_clk = ~i_clk;

    vector3_normalize_unit #(.FRAC_BITS(FB)) u_dut (.*);

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] rem, root, b;
        rem = v;
        root = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic [UW-1:0] unit_comp(logic [IN_W-1:0] c, logic [63:0] len);
        logic [63:0] a, q;
        a = c[IN_W-1] ? 64'(-c) & 64'hFFFF_FFFF : 64'(c);
        q = (a << FB) / len;
        if (c[IN_W-1]) q = -q;
        return q[UW-1:0];
    endfunction

    function automatic unit_vec_t normalise(logic [IN_W-1:0] x, logic [IN_W-1:0] y,
                                            logic [IN_W-1:0] z);
        unit_vec_t r;
        logic [63:0] ax, ay, az, len;
        ax = x[IN_W-1] ? (64'(-x) & 64'hFFFF_FFFF) : 64'(x);
        ay = y[IN_W-1] ? (64'(-y) & 64'hFFFF_FFFF) : 64'(y);
        az = z[IN_W-1] ? (64'(-z) & 64'hFFFF_FFFF) : 64'(z);
        len = root_floor(ax * ax + ay * ay + az * az);
        r = '0;
        if (len == 0) begin
            r.zero = 1'b1;
        end else begin
            r.ux = unit_comp(x, len);
            r.uy = unit_comp(y, len);
            r.uz = unit_comp(z, len);
            r.mag = len[MAG_W-1:0];
        end
        return r;
    endfunction

    task automatic send_beat(logic [IN_W-1:0] x, logic [IN_W-1:0] y, logic [IN_W-1:0] z,
                             bit known, unit_vec_t res);
        i_valid <= 1'b1;
        i_vec_x <= x;
        i_vec_y <= y;
        i_vec_z <= z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_q.push_back(known ? res : normalise(x, y, z));
        n_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [IN_W-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 255);
            1: return -$urandom_range(0, 255);
            2: return $urandom_range(0, 32'h3_FFFF) - 32'h1_FFFF;
            3: return $signed({$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom)})
                      >>> $urandom_range(0, 20);
            4: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // receiver stall pattern
    int stall_len = 0;
    always @(negedge i_clk) begin
        if (stall_len > 0) begin
            stall_len <= stall_len - 1;
            i_ready <= 1'b0;
        end else if (cycles > 3000 && cycles < 6000) begin
            i_ready <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_len <= $urandom_range(0, 12);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        unit_vec_t exp_r;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            n_got++;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (exp_r.zero) n_zero++;
                if (o_unit_x !== exp_r.ux) begin
                    $error("unit_x expected %0d got %0d", exp_r.ux, o_unit_x); errors++;
                end
                if (o_unit_y !== exp_r.uy) begin
                    $error("unit_y expected %0d got %0d", exp_r.uy, o_unit_y); errors++;
                end
                if (o_unit_z !== exp_r.uz) begin
                    $error("unit_z expected %0d got %0d", exp_r.uz, o_unit_z); errors++;
                end
                if (o_magnitude !== exp_r.mag) begin
                    $error("magnitude expected %0d got %0d", exp_r.mag, o_magnitude); errors++;
                end
                if (o_zero_vector !== exp_r.zero) begin
                    $error("zero_vector expected %0d got %0d", exp_r.zero, o_zero_vector);
                    errors++;
                end
            end
        end
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("vector3_normalize_unit verification failed");
            $finish;
        end
    end

    localparam logic [IN_W-1:0] ONE = 32'h0001_0000;
    localparam logic [IN_W-1:0] MAXP = 32'h7FFF_FFFF;
    localparam logic [IN_W-1:0] MINN = 32'h8000_0000;
    localparam unit_vec_t R_ZERO = '{ux: 0, uy: 0, uz: 0, mag: 0, zero: 1'b1};
    localparam unit_vec_t R_X1 = '{ux: 65536, uy: 0, uz: 0, mag: 32'h1_0000, zero: 1'b0};
    localparam unit_vec_t R_ZN = '{ux: 0, uy: 0, uz: -65536, mag: 32'h8000_0000, zero: 1'b0};
    localparam unit_vec_t R_TINY = '{ux: 0, uy: 65536, uz: 0, mag: 32'd1, zero: 1'b0};
    localparam unit_vec_t R_NONE = '0;

    stim_row_t directed[] = '{
        '{32'd0, 32'd0, 32'd0, 1'b1, R_ZERO},
        '{ONE, 32'd0, 32'd0, 1'b1, R_X1},
        '{32'd0, 32'd0, MINN, 1'b1, R_ZN},
        '{32'd0, 32'd1, 32'd0, 1'b1, R_TINY},
        '{32'd1, 32'd1, 32'd1, 1'b0, R_NONE},
        '{MAXP, MAXP, MAXP, 1'b0, R_NONE},
        '{MINN, MINN, MINN, 1'b0, R_NONE},
        '{MAXP, MINN, 32'd0, 1'b0, R_NONE},
        '{-ONE, ONE, -ONE, 1'b0, R_NONE},
        '{32'd3 << 16, 32'd4 << 16, 32'd0, 1'b0, R_NONE},
        '{32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0, R_NONE},
        '{32'd12345, -32'd678, 32'd9, 1'b0, R_NONE},
        '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 1'b0, R_NONE},
        '{MINN, 32'd1, MAXP, 1'b0, R_NONE}
    };

    initial begin
        int burst;
        bit drained;
        drained = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[k])
            send_beat(directed[k].x, directed[k].y, directed[k].z,
                      directed[k].known, directed[k].res);
        for (int k = 0; k < N_RAND;) begin
            if (!drained && k >= N_RAND / 2) begin
                drained = 1'b1;
                i_valid <= 1'b0;
                while (expected_q.size() != 0) @(negedge i_clk);
            end
            burst = $urandom_range(1, 20);
            for (int j = 0; j < burst && k < N_RAND; j++, k++) begin
                if ($urandom_range(0, 19) == 0)
                    send_beat(0, 0, 0, 1'b0, R_NONE);
                else
                    send_beat(rand_comp(), rand_comp(), rand_comp(), 1'b0, R_NONE);
            end
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
        end
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (LAT + 10) @(negedge i_clk);
        $display("sent %0d vectors, checked %0d results (%0d zero-length)",
                 n_sent, n_got, n_zero);
        if (errors == 0)
            $display("vector3_normalize_unit verification clean");
        else
            $display("vector3_normalize_unit verification failed");
        $finish;
    end

endmodule

>>> vector3_normalize_unit.f
hw/rtl/v3n_pkg.sv
hw/rtl/vector3_normalize_unit.sv
bench/vector3_normalize_unit_test.sv
